FILE: rtl/rif_pkg.sv
package rif_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_BITS    = 8;
    localparam int DIGIT_BITS  = 4;
    localparam int RADIX_BITS  = 5;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 64;

    localparam logic [SYM_BITS-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_BITS-1:0] CHAR_MINUS = 8'h2D;

    localparam logic [1:0] REG_SYM_LO   = 2'd0;
    localparam logic [1:0] REG_SYM_HI   = 2'd1;
    localparam logic [1:0] REG_BASE_LEN = 2'd2;

    localparam logic [RADIX_BITS-1:0] BASE_LEN_RESET = 5'd10;

    typedef logic [SYM_BITS-1:0] t_symbol;
    typedef t_symbol [MAX_SYMBOLS-1:0] t_alphabet;

    typedef struct packed {
        logic load;
        logic step;
        logic prep;
        logic emit_sign;
        logic emit_digit;
        logic emit_err;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic bit_last;
        logic negative;
        logic idx_zero;
    } t_dp_status;

endpackage

FILE: rtl/rif_if.sv
interface rif_value_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface rif_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic       invalid_base;

    modport source (output valid, output character, output last, output invalid_base,
                    input ready);
    modport sink (input valid, input character, input last, input invalid_base,
                  output ready);
endinterface

FILE: rtl/rif_cfg.sv
module rif_cfg import rif_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output t_alphabet                o_alphabet,
    output logic [RADIX_BITS-1:0]    o_radix,
    output logic                     o_alpha_ok
);

    logic [APB_DATA_BITS-1:0] r_sym_lo;
    logic [APB_DATA_BITS-1:0] r_sym_hi;
    logic [RADIX_BITS-1:0]    r_base_len;
    logic                     r_alpha_ok;
    logic                     n_alpha_ok;
    logic                     wr_en;
    logic [1:0]               reg_sel;
    t_alphabet                alphabet;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_lo   <= '0;
            r_sym_hi   <= '0;
            r_base_len <= BASE_LEN_RESET;
            r_alpha_ok <= 1'b0;
        end else begin
            r_alpha_ok <= n_alpha_ok;
            if (wr_en) begin
                unique case (reg_sel)
                    REG_SYM_LO:   r_sym_lo   <= pwdata;
                    REG_SYM_HI:   r_sym_hi   <= pwdata;
                    REG_BASE_LEN: r_base_len <= pwdata[RADIX_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SYM_LO:   prdata = r_sym_lo;
            REG_SYM_HI:   prdata = r_sym_hi;
            REG_BASE_LEN: prdata = {{(APB_DATA_BITS-RADIX_BITS){1'b0}}, r_base_len};
            default:      prdata = '0;
        endcase
    end

    assign alphabet = {r_sym_hi, r_sym_lo};

    // Only the symbols in use are checked for signs and duplicates.
    always_comb begin
        n_alpha_ok = (r_base_len >= RADIX_BITS'(2))
                     && (r_base_len <= RADIX_BITS'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (RADIX_BITS'(i) < r_base_len) begin
                if ((alphabet[i] == CHAR_PLUS) || (alphabet[i] == CHAR_MINUS)) begin
                    n_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if ((RADIX_BITS'(j) < r_base_len) && (alphabet[i] == alphabet[j])) begin
                        n_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign o_alphabet = alphabet;
    assign o_radix    = r_base_len;
    assign o_alpha_ok = r_alpha_ok;

endmodule

FILE: rtl/rif_dp.sv
module rif_dp import rif_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  t_alphabet                    i_alphabet,
    input  logic [RADIX_BITS-1:0]        i_radix,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [SYM_BITS-1:0]          o_character,
    output logic                         o_last,
    output logic                         o_invalid_base
);

    localparam int DIGITS = VALUE_BITS;
    localparam int CW     = $clog2(DIGITS + 1);
    localparam int IW     = $clog2(DIGITS);

    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [DIGIT_BITS-1:0] r_digits [DIGITS];
    logic [DIGIT_BITS-1:0] n_digits [DIGITS];
    logic [CW-1:0]         r_count;
    logic [IW-1:0]         r_bit_cnt;
    logic [IW-1:0]         r_idx;
    logic                  r_out_valid;
    logic [SYM_BITS-1:0]   r_out_char;
    logic                  r_out_last;
    logic                  r_out_err;

    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] mag_in;
    logic [DIGITS-1:0]     gen;
    logic [DIGITS-1:0]     prop;
    logic [DIGITS:0]       sum;
    logic [DIGITS:0]       carry;
    logic [CW-1:0]         idx_init;

    assign raw    = i_value;
    assign mag_in = raw[VALUE_BITS-1] ? ((~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

    // Each step doubles the digit vector and adds the next magnitude bit. A digit
    // carries when 2d+cin reaches the radix; the carry chain is resolved by one
    // add of the generate and propagate vectors.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            gen[i]  = {1'b0, r_digits[i], 1'b0} >= {1'b0, i_radix};
            prop[i] = {1'b0, r_digits[i], 1'b1} == {1'b0, i_radix};
        end
        sum   = {1'b0, gen | prop} + {1'b0, gen} + {{DIGITS{1'b0}}, r_mag[VALUE_BITS-1]};
        carry = {sum[DIGITS], sum[DIGITS-1:0] ^ prop};
        for (int i = 0; i < DIGITS; i++) begin
            if (carry[i+1]) begin
                n_digits[i] = DIGIT_BITS'({r_digits[i], carry[i]} - i_radix);
            end else begin
                n_digits[i] = DIGIT_BITS'({r_digits[i], carry[i]});
            end
        end
    end

    assign idx_init = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag     <= mag_in;
            r_neg     <= raw[VALUE_BITS-1];
            r_bit_cnt <= IW'(VALUE_BITS - 1);
            for (int i = 0; i < DIGITS; i++) begin
                r_digits[i] <= '0;
            end
        end else if (i_cmd.step) begin
            r_mag     <= {r_mag[VALUE_BITS-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt - IW'(1);
            r_digits  <= n_digits;
        end
        if (i_cmd.prep) begin
            r_idx <= idx_init[IW-1:0];
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= CW'(1);
        end else if (i_cmd.step) begin
            r_count <= r_count + CW'(carry[r_count]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_err || i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_err) begin
            r_out_char <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (i_cmd.emit_sign) begin
            r_out_char <= CHAR_MINUS;
            r_out_last <= 1'b0;
            r_out_err  <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= i_alphabet[r_digits[r_idx]];
            r_out_last <= (r_idx == '0);
            r_out_err  <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.bit_last = (r_bit_cnt == '0);
    assign o_status.negative = r_neg;
    assign o_status.idx_zero = (r_idx == '0);

    assign o_out_valid    = r_out_valid;
    assign o_character    = r_out_char;
    assign o_last         = r_out_last;
    assign o_invalid_base = r_out_err;

endmodule

FILE: rtl/rif_ctrl.sv
module rif_ctrl import rif_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_alpha_ok,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_ERR   = 7'b0000100,
        S_CONV  = 7'b0001000,
        S_PREP  = 7'b0010000,
        S_SIGN  = 7'b0100000,
        S_DIGIT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = i_alpha_ok ? S_CONV : S_ERR;
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.bit_last) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.negative ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/radix_integer_formatter.sv
// Writes a signed integer as text in a radix set by a configured alphabet.
// The input channel carries one value per transfer. The output channel carries
// one character per transfer, most significant digit first, with a leading
// minus sign for negative values and last set on the final character.
// If the alphabet is invalid, the value produces a single transfer with
// character zero and both last and invalid_base set.
// The alphabet and its length are to be written over the APB port while the
// block is idle; the block itself does not enforce this. Reads return the
// register contents. A value is converted one bit of the magnitude per cycle
// through the digit-doubling carry chain, and its characters then follow one
// per cycle while the receiver accepts them.
// The next value is accepted in the cycle after the final character is
// loaded into the output register.
// A stalled receiver holds the current character in the output register and
// pauses the character sequence; nothing is dropped.
// Reset returns the block to idle with an empty output register, clears both
// symbol registers and sets the alphabet length to ten.
module radix_integer_formatter import rif_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    rif_value_if.sink                i_value_stream,
    rif_char_if.source               o_char_stream,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    t_alphabet               alphabet;
    logic [RADIX_BITS-1:0]   radix;
    logic                    alpha_ok;
    t_dp_cmd                 dp_cmd;
    t_dp_status              dp_status;
    logic                    in_ready;
    logic [VALUE_BITS-1:0]   value_bits;

    assign value_bits = VALUE_BITS'(i_value_stream.value);

    rif_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_alphabet (alphabet),
        .o_radix    (radix),
        .o_alpha_ok (alpha_ok)
    );

    rif_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value_stream.valid),
        .o_in_ready (in_ready),
        .i_alpha_ok (alpha_ok),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    rif_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_value        (signed'(value_bits)),
        .i_alphabet     (alphabet),
        .i_radix        (radix),
        .i_out_ready    (o_char_stream.ready),
        .o_out_valid    (o_char_stream.valid),
        .o_character    (o_char_stream.character),
        .o_last         (o_char_stream.last),
        .o_invalid_base (o_char_stream.invalid_base)
    );

    assign i_value_stream.ready = in_ready;

endmodule

FILE: dv/tb_radix_integer_formatter.sv
`timescale 1ns / 100ps

module tb_radix_integer_formatter;
    import rif_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        t_symbol character;
        logic    last;
        logic    invalid_base;
    } t_char_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    rif_value_if #(.VALUE_BITS(VALUE_BITS)) value_if ();
    rif_char_if char_if ();

    radix_integer_formatter #(.VALUE_BITS(VALUE_BITS)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_value_stream (value_if),
        .o_char_stream  (char_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    logic [63:0]                  cfg_sym_lo;
    logic [63:0]                  cfg_sym_hi;
    logic [RADIX_BITS-1:0]        cfg_base_len;
    logic signed [VALUE_BITS-1:0] pending_values[$];
    t_char_result                 expected_chars[$];
    int                           send_idle_pct;
    int                           recv_stall_pct;
    int                           mismatch_count;
    t_char_result                 seen_char;
    t_char_result                 wanted_char;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_symbol symbol_of(input int k);
        if (k < 8) begin
            return cfg_sym_lo[8*k +: 8];
        end
        return cfg_sym_hi[8*(k-8) +: 8];
    endfunction

    function automatic bit alphabet_valid();
        int n;
        n = int'(cfg_base_len);
        if (n < 2 || n > MAX_SYMBOLS) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (symbol_of(i) == CHAR_PLUS || symbol_of(i) == CHAR_MINUS) begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++) begin
                if (symbol_of(i) == symbol_of(j)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queues the characters that one value turns into under the current alphabet.
    function automatic void predict_text(input logic signed [VALUE_BITS-1:0] v);
        logic [VALUE_BITS-1:0] mag;
        logic [DIGIT_BITS-1:0] digits [0:VALUE_BITS-1];
        logic [VALUE_BITS-1:0] radix;
        int                    n;
        if (!alphabet_valid()) begin
            expected_chars.push_back('{character: '0, last: 1'b1, invalid_base: 1'b1});
            return;
        end
        radix = VALUE_BITS'(cfg_base_len);
        mag = v[VALUE_BITS-1] ? (~$unsigned(v) + 1'b1) : $unsigned(v);
        n = 0;
        do begin
            digits[n] = DIGIT_BITS'(mag % radix);
            mag = mag / radix;
            n++;
        end while (mag != 0);
        if (v[VALUE_BITS-1]) begin
            expected_chars.push_back('{character: CHAR_MINUS, last: 1'b0, invalid_base: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            expected_chars.push_back('{character: symbol_of(digits[i]), last: (i == 0),
                                       invalid_base: 1'b0});
        end
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] raw;
        raw = $urandom;
        case ($urandom_range(9))
            0, 1: raw = raw >> $urandom_range(31);
            2, 3: raw = -(raw >> $urandom_range(31));
            4: raw = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            5: raw = $urandom_range(20) - 10;
            default: ;
        endcase
        return raw;
    endfunction

    // Distinct symbols in the used positions, free bytes in the rest.
    function automatic logic [127:0] random_alphabet(input int radix);
        logic [127:0] syms;
        bit           taken [0:255];
        logic [7:0]   s;
        for (int k = 0; k < 256; k++) begin
            taken[k] = 1'b0;
        end
        taken[CHAR_PLUS] = 1'b1;
        taken[CHAR_MINUS] = 1'b1;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            if (k < radix) begin
                do s = 8'($urandom_range(255)); while (taken[s]);
                taken[s] = 1'b1;
            end else begin
                s = 8'($urandom_range(255));
            end
            syms[8*k +: 8] = s;
        end
        return syms;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SYM_LO:   cfg_sym_lo = data;
            REG_SYM_HI:   cfg_sym_hi = data;
            REG_BASE_LEN: cfg_base_len = data[RADIX_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_alphabet(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [RADIX_BITS-1:0] len);
        write_reg(REG_SYM_LO, lo);
        write_reg(REG_SYM_HI, hi);
        write_reg(REG_BASE_LEN, {{(64-RADIX_BITS){1'b0}}, len});
    endtask

    // Holds off until every queued value is sent and every character has arrived.
    task automatic drain();
        while (pending_values.size() != 0 || value_if.valid || expected_chars.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_random_alphabet();
        int                    pick;
        int                    radix;
        int                    pos;
        logic [127:0]          syms;
        logic [RADIX_BITS-1:0] len;
        pick = $urandom_range(99);
        radix = (pick < 10) ? 2 : (pick < 20) ? MAX_SYMBOLS : $urandom_range(2, MAX_SYMBOLS);
        syms = random_alphabet(radix);
        len = RADIX_BITS'(radix);
        pos = $urandom_range(radix - 1);
        if (pick >= 85) begin
            case (pick % 5)
                0: len = RADIX_BITS'($urandom_range(1));
                1: len = RADIX_BITS'($urandom_range(17, 31));
                2: syms[8*pos +: 8] = CHAR_PLUS;
                3: syms[8*pos +: 8] = CHAR_MINUS;
                default: syms[8*((pos + 1) % radix) +: 8] = syms[8*pos +: 8];
            endcase
        end
        set_alphabet(syms[63:0], syms[127:64], len);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            value_if.valid <= 1'b0;
            value_if.value <= '0;
        end else begin
            if (value_if.valid && value_if.ready) begin
                predict_text(value_if.value);
            end
            if (!value_if.valid || value_if.ready) begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    value_if.valid <= 1'b1;
                    value_if.value <= pending_values.pop_front();
                end else begin
                    value_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_if.ready <= 1'b0;
        end else begin
            if (char_if.valid && char_if.ready) begin
                seen_char = '{character: char_if.character, last: char_if.last,
                              invalid_base: char_if.invalid_base};
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: character transfer with nothing expected, got %h", $time,
                             seen_char);
                end else begin
                    wanted_char = expected_chars.pop_front();
                    if (seen_char.character !== wanted_char.character) begin
                        mismatch_count++;
                        $display("%0t: character expected %h got %h", $time,
                                 wanted_char.character, seen_char.character);
                    end
                    if (seen_char.last !== wanted_char.last) begin
                        mismatch_count++;
                        $display("%0t: last expected %b got %b", $time,
                                 wanted_char.last, seen_char.last);
                    end
                    if (seen_char.invalid_base !== wanted_char.invalid_base) begin
                        mismatch_count++;
                        $display("%0t: invalid_base expected %b got %b", $time,
                                 wanted_char.invalid_base, seen_char.invalid_base);
                    end
                end
            end
            char_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #(10_000_000);
        $display("tb_radix_integer_formatter: done, errors");
        $finish;
    end

    initial begin
        value_if.valid = 1'b0;
        value_if.value = '0;
        char_if.ready  = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_rst_n        = 1'b0;
        cfg_sym_lo     = '0;
        cfg_sym_hi     = '0;
        cfg_base_len   = BASE_LEN_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The reset alphabet is all zero bytes, so it repeats a symbol.
        pending_values.push_back(12345);
        drain();

        set_alphabet("76543210", {48'd0, "98"}, 5'd10);
        pending_values.push_back(0);
        pending_values.push_back(1);
        pending_values.push_back(-1);
        pending_values.push_back(10);
        pending_values.push_back(-10);
        pending_values.push_back(32'sh7FFF_FFFF);
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(1000000000);
        drain();

        set_alphabet({48'd0, "10"}, '0, 5'd2);
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(32'sh7FFF_FFFF);
        pending_values.push_back(0);
        drain();

        set_alphabet("76543210", "FEDCBA98", 5'd16);
        write_reg(REG_UNUSED, '1);
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(-1);
        pending_values.push_back(32'sh7FFF_FFFF);
        pending_values.push_back(32'sh1234_5678);
        drain();

        // A zero byte is an ordinary symbol, and symbols past the radix are not checked.
        set_alphabet({16'd0, "a-+", "ba", 8'h00}, '0, 5'd3);
        pending_values.push_back(-7);
        pending_values.push_back(5);
        drain();

        for (int k = 0; k < 7; k++) begin
            case (k)
                0: set_alphabet("76543210", {48'd0, "98"}, 5'd0);
                1: set_alphabet("76543210", {48'd0, "98"}, 5'd1);
                2: set_alphabet("76543210", "FEDCBA98", 5'd17);
                3: set_alphabet("76543210", "FEDCBA98", 5'd31);
                4: set_alphabet("765+3210", {48'd0, "98"}, 5'd10);
                5: set_alphabet("7654321-", {48'd0, "98"}, 5'd10);
                default: set_alphabet("76543210", "FEDCBA97", 5'd16);
            endcase
            pending_values.push_back(random_value());
            drain();
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                apply_random_alphabet();
                repeat ($urandom_range(16, 28)) pending_values.push_back(random_value());
                drain();
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        repeat (80) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_radix_integer_formatter: done, clean");
        end else begin
            $display("tb_radix_integer_formatter: done, errors");
        end
        $finish;
    end

endmodule
